>>> rtl/mmsg_pkg.sv
package mmsg_pkg;
    localparam int NODES_DEF   = 256;
    localparam int TARGETS_DEF = 256;
    localparam int ENTRIES_DEF = 4096;
    localparam int WBITS_DEF   = 16;
    localparam logic [8:0] UNMAPPED = 9'h1FF;

    localparam logic [2:0] REQ_MAP   = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_MOVE  = 3'd2;
    localparam logic [2:0] REQ_SWAP  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] node_a;
        logic [8:0] target_a;
        logic [7:0] node_b;
        logic [8:0] target_b;
        logic [7:0] dep_node;
        logic [7:0] dep_target;
        logic       dep_always;
        logic [15:0] weight;
    } t_req;

    typedef struct packed {
        logic [31:0] gain;
        logic        status;
    } t_rsp;
endpackage

>>> rtl/mmsg_if.sv
interface mmsg_req_if;
    logic valid;
    logic ready;
    mmsg_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmsg_rsp_if;
    logic valid;
    logic ready;
    mmsg_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mapping_move_swap_gain.sv
// load items pass through S_LOAD; move and swap queries scan every stored entry, then drain
// throughput: one item at a time; a query streams the weight memory one entry a cycle
// reset: synchronous active low; then a sweep sets every mapping entry
// to unmapped before the first item is taken; weight entries stay
// undefined until appended, entry_count reads zero
module mapping_move_swap_gain #(
    parameter int NODES       = mmsg_pkg::NODES_DEF,
    parameter int TARGETS     = mmsg_pkg::TARGETS_DEF,
    parameter int ENTRIES     = mmsg_pkg::ENTRIES_DEF,
    parameter int WEIGHT_BITS = mmsg_pkg::WBITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mmsg_req_if.sink   i_req,
    mmsg_rsp_if.source o_rsp
);
    localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EB = $clog2(ENTRIES);
    // stored weight width, the weight field itself carries 16 bits
    localparam int SW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int CW = SW + 3;
    localparam int WW = 8 + 9 + 8 + 8 + 1 + SW;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DRN2  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    mmsg_pkg::t_req r_req;
    logic [NB:0] r_init;
    logic [EB:0] r_count;   // entry_count
    logic [EB:0] r_idx;     // scan address
    logic        r_rd_v, r_ev;  // entry read in flight, entry data valid
    logic [47:0] r_acc;     // wide signed accumulator
    logic        r_status;

    // mapping memory, one read port for the dependency lookup
    logic [8:0]  r_map [NODES];
    logic [8:0]  r_map_q;
    // weight memory
    logic [WW-1:0] r_ws [ENTRIES];
    logic [WW-1:0] r_ws_q;
    logic [WW-1:0] r_ent;    // entry held while its dependency is looked up

    // unpack registered entry
    logic [7:0] e_kn, e_dn, e_dt;
    logic [8:0] e_kt;
    logic       e_al;
    logic [SW-1:0] e_w;
    assign {e_kn, e_kt, e_dn, e_dt, e_al, e_w} = r_ent;

    logic r_map_addr_ok;

    // key roles: lo/hi node and targets
    logic        swap;
    logic [7:0]  lo, hi;
    logic [8:0]  lo_new, lo_old, hi_new, hi_old;
    always_comb begin
        swap = (r_req.req_type == mmsg_pkg::REQ_SWAP);
        if (r_req.node_a > r_req.node_b) begin
            lo = r_req.node_b; lo_new = r_req.target_a; lo_old = r_req.target_b;
            hi = r_req.node_a; hi_new = r_req.target_b; hi_old = r_req.target_a;
        end else begin
            lo = r_req.node_a; lo_new = r_req.target_b; lo_old = r_req.target_a;
            hi = r_req.node_b; hi_new = r_req.target_a; hi_old = r_req.target_b;
        end
    end

    // dependency value under stored and tentative mapping
    logic [8:0] dep_old, dep_new;
    logic signed [CW-1:0] contrib;
    logic [SW:0] wx;
    always_comb begin
        dep_old = (r_map_addr_ok) ? r_map_q : mmsg_pkg::UNMAPPED;
        dep_new = dep_old;
        if (r_req.req_type == mmsg_pkg::REQ_MOVE) begin
            if (e_dn == r_req.node_a) dep_new = r_req.target_a;
        end else begin
            if (e_dn == r_req.node_a) dep_new = r_req.target_b;
            if (e_dn == r_req.node_b) dep_new = r_req.target_a;
        end
        wx = {1'b0, e_w};
        contrib = '0;
        if (!swap) begin
            if (e_kn == r_req.node_a && e_kt == r_req.target_a
                && (e_al || dep_new == {1'b0, e_dt}))
                contrib = contrib + CW'($signed({1'b0, wx}));
            if (e_kn == r_req.node_a && e_kt == r_req.target_b
                && (e_al || dep_old == {1'b0, e_dt}))
                contrib = contrib - CW'($signed({1'b0, wx}));
        end else begin
            if (e_kn == lo && e_kt == lo_new && (e_al || dep_new == {1'b0, e_dt}))
                contrib = contrib + CW'($signed({1'b0, wx}));
            if (e_kn == hi && e_kt == hi_new
                && (e_al || (e_dn != lo && dep_new == {1'b0, e_dt})))
                contrib = contrib + CW'($signed({1'b0, wx}));
            if (e_kn == lo && e_kt == lo_old && (e_al || dep_old == {1'b0, e_dt}))
                contrib = contrib - CW'($signed({1'b0, wx}));
            if (e_kn == hi && e_kt == hi_old
                && (e_al || (e_dn != lo && dep_old == {1'b0, e_dt})))
                contrib = contrib - CW'($signed({1'b0, wx}));
        end
    end

    logic [8:0] map_wv;
    always_comb begin
        map_wv = r_req.target_a;
        if (map_wv[8] ? (map_wv != mmsg_pkg::UNMAPPED) : (32'(map_wv) >= TARGETS))
            map_wv = mmsg_pkg::UNMAPPED;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT)
            r_map[r_init[NB-1:0]] <= mmsg_pkg::UNMAPPED;
        else if (r_state == S_LOAD && r_req.req_type == mmsg_pkg::REQ_MAP
                 && 32'(r_req.node_a) < NODES)
            r_map[NB'(r_req.node_a)] <= map_wv;
        r_map_q <= r_map[NB'(r_ws_q[WW-18 -: 8])];
        r_map_addr_ok <= (32'(r_ws_q[WW-18 -: 8]) < NODES);
        if (r_state == S_LOAD && r_req.req_type == mmsg_pkg::REQ_APPEND
            && r_count < (EB+1)'(ENTRIES))
            r_ws[r_count[EB-1:0]] <= {r_req.node_a, r_req.target_a, r_req.dep_node,
                                      r_req.dep_target, r_req.dep_always,
                                      r_req.weight[SW-1:0]};
        r_ws_q <= r_ws[r_idx[EB-1:0]];
        r_ent  <= r_ws_q;
    end

    // control: read entry, look up dependency, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init <= '0;
            r_count <= '0;
            r_idx <= '0;
            r_rd_v <= 1'b0;
            r_ev <= 1'b0;
            r_status <= 1'b0;
            r_acc <= '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (32'(r_init) == NODES - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_acc <= '0;
                        r_status <= 1'b0;
                        r_idx <= '0;
                        r_rd_v <= 1'b0;
                        r_ev <= 1'b0;
                        if (i_req.data.req_type == mmsg_pkg::REQ_MOVE
                            || i_req.data.req_type == mmsg_pkg::REQ_SWAP)
                            r_state <= S_SCAN;
                        else
                            r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_req.req_type == mmsg_pkg::REQ_APPEND) begin
                        if (r_count < (EB+1)'(ENTRIES)) r_count <= r_count + 1'b1;
                        else r_status <= 1'b1;
                    end else if (r_req.req_type == mmsg_pkg::REQ_CLEAR) begin
                        r_count <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    r_ev <= r_rd_v;
                    if (r_ev) r_acc <= r_acc + 48'($signed(contrib));
                    if (r_idx < r_count) begin
                        r_rd_v <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_ev <= r_rd_v;
                    if (r_ev) r_acc <= r_acc + 48'($signed(contrib));
                    r_state <= S_DRN2;
                end
                S_DRN2: begin
                    r_ev <= 1'b0;
                    if (r_ev) r_acc <= r_acc + 48'($signed(contrib));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // saturate to 32 bits
    logic signed [47:0] acc_s;
    always_comb begin
        acc_s = $signed(r_acc);
        if (acc_s > 48'sd2147483647)       o_rsp.data.gain = 32'h7FFFFFFF;
        else if (acc_s < -48'sd2147483648) o_rsp.data.gain = 32'h80000000;
        else                               o_rsp.data.gain = r_acc[31:0];
        o_rsp.data.status = r_status;
    end
endmodule
